/* rtl/core/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types, constants and table functions of the character to
// prefix-code transcoder.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // Input word: an item kind and the character to transcode.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
    } t_in_word;

    // Output word: one decoded character or a line marker.
    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       last_of_item;
    } t_out_word;

    // Item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Pending bit string and counter widths.
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;
    localparam int CODE_W = 5;

    // Codes of the punctuation characters.
    localparam logic [CODE_W-1:0] CODE_SPACE    = 5'd26;
    localparam logic [CODE_W-1:0] CODE_PERIOD   = 5'd27;
    localparam logic [CODE_W-1:0] CODE_COMMA    = 5'd28;
    localparam logic [CODE_W-1:0] CODE_HYPHEN   = 5'd29;
    localparam logic [CODE_W-1:0] CODE_APOSTR   = 5'd30;
    localparam logic [CODE_W-1:0] CODE_QUESTION = 5'd31;

    // Result of decoding one input word against the current state.
    typedef struct packed {
        logic [1:0]        count;
        t_out_word         word0;
        t_out_word         word1;
        logic              upd;
        logic [PEND_W-1:0] bits;
        logic [CNT_W-1:0]  cnt;
    } t_dec_result;

    // Codeword table: length, right-aligned bits, character.
    localparam int NUM_WORDS = 32;
    localparam logic [19:0] CODEWORDS [NUM_WORDS] = '{
        {4'd3, 8'h05, 8'h20}, {4'd6, 8'h00, 8'h27}, {4'd6, 8'h03, 8'h2C},
        {4'd8, 8'h91, 8'h2D}, {4'd6, 8'h11, 8'h2E}, {4'd6, 8'h01, 8'h3F},
        {4'd6, 8'h25, 8'h41}, {4'd8, 8'h9A, 8'h42}, {4'd4, 8'h05, 8'h43},
        {4'd4, 8'h01, 8'h44}, {4'd3, 8'h06, 8'h45}, {4'd5, 8'h09, 8'h46},
        {4'd8, 8'h9B, 8'h47}, {4'd6, 8'h10, 8'h48}, {4'd4, 8'h07, 8'h49},
        {4'd8, 8'h98, 8'h4A}, {4'd4, 8'h06, 8'h4B}, {4'd5, 8'h04, 8'h4C},
        {4'd8, 8'h99, 8'h4D}, {4'd8, 8'h9E, 8'h4E}, {4'd5, 8'h05, 8'h4F},
        {4'd3, 8'h07, 8'h50}, {4'd8, 8'h9F, 8'h51}, {4'd4, 8'h08, 8'h52},
        {4'd5, 8'h06, 8'h53}, {4'd5, 8'h07, 8'h54}, {4'd8, 8'h9C, 8'h55},
        {4'd8, 8'h9D, 8'h56}, {4'd6, 8'h02, 8'h57}, {4'd8, 8'h92, 8'h58},
        {4'd8, 8'h93, 8'h59}, {4'd8, 8'h90, 8'h5A}
    };

    // Maps a character to its 5-bit code; bit 5 of the result flags a hit.
    function automatic logic [CODE_W:0] char_code(input logic [7:0] c);
        logic [CODE_W:0] res;
        res = '0;
        case (c) inside
            [8'h41:8'h5A]: res = {1'b1, 5'(c - 8'h41)};
            8'h20:         res = {1'b1, CODE_SPACE};
            8'h2E:         res = {1'b1, CODE_PERIOD};
            8'h2C:         res = {1'b1, CODE_COMMA};
            8'h2D:         res = {1'b1, CODE_HYPHEN};
            8'h27:         res = {1'b1, CODE_APOSTR};
            8'h3F:         res = {1'b1, CODE_QUESTION};
            default:       res = '0;
        endcase
        return res;
    endfunction

    // Looks up a pending string; bit 8 of the result flags a match.
    function automatic logic [8:0] match_word(input logic [3:0] len,
                                              input logic [7:0] bits);
        logic [8:0] res;
        res = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (CODEWORDS[i][19:16] == len && CODEWORDS[i][15:8] == bits) begin
                res = {1'b1, CODEWORDS[i][7:0]};
            end
        end
        return res;
    endfunction

endpackage

/* rtl/core/ctp_decode.sv */
// ----------------------------------------------------------------------------
// ctp_decode
// Combinational decode of one input word: shifts the five code bits into
// the pending string and matches after each bit.
// ----------------------------------------------------------------------------
module ctp_decode (
    input  ctp_pkg::t_in_word               i_word,
    input  logic [ctp_pkg::PEND_W-1:0]      i_bits,
    input  logic [ctp_pkg::CNT_W-1:0]       i_cnt,
    output ctp_pkg::t_dec_result            o_res
);
    import ctp_pkg::*;

    // Five unrolled bit steps, each followed by a table match.
    always_comb begin
        logic [CODE_W:0] code;
        logic [7:0]      bits;
        logic [3:0]      cnt;
        logic [8:0]      hit;
        o_res       = '0;
        code        = char_code(i_word.char_in);
        bits        = {1'b0, i_bits};
        cnt         = {1'b0, i_cnt};
        hit         = '0;
        if (i_word.kind == KIND_EOL) begin
            // End of line drops the pending bits and emits a line marker.
            o_res.count              = 2'd1;
            o_res.word0.line_end     = 1'b1;
            o_res.word0.last_of_item = 1'b1;
            o_res.upd                = 1'b1;
        end else if (code[CODE_W]) begin
            for (int b = CODE_W - 1; b >= 0; b--) begin
                bits = {bits[6:0], code[b]};
                cnt  = cnt + 4'd1;
                hit  = match_word(cnt, bits);
                if (hit[8]) begin
                    if (o_res.count == 2'd0) begin
                        o_res.word0.out_char = hit[7:0];
                    end else begin
                        o_res.word1.out_char = hit[7:0];
                    end
                    if (o_res.count != 2'd2) begin
                        o_res.count = o_res.count + 2'd1;
                    end
                    bits = '0;
                    cnt  = '0;
                end else if (cnt >= 4'd8) begin
                    bits = '0;
                    cnt  = '0;
                end
            end
            // Flag the final result of this word.
            if (o_res.count == 2'd1) begin
                o_res.word0.last_of_item = 1'b1;
            end else if (o_res.count == 2'd2) begin
                o_res.word1.last_of_item = 1'b1;
            end
            o_res.upd  = 1'b1;
            o_res.bits = bits[PEND_W-1:0];
            o_res.cnt  = cnt[CNT_W-1:0];
        end
    end

endmodule

/* rtl/core/char_to_prefix_code_transcoder_unit.sv */
// ----------------------------------------------------------------------------
// char_to_prefix_code_transcoder_unit
// Transcodes characters into 5-bit codes and decodes the bit stream with a
// fixed prefix code, emitting one output word per codeword or line marker.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_word) carries one word
// per character or end-of-line marker. The output channel (o_out_valid /
// i_out_ready / o_out_word) carries decoded characters and line markers;
// last_of_item flags the final output word caused by an input word.
// An input word is decoded in the cycle it is accepted, and its output
// words are written to a four-entry output queue, so the first result is
// visible in the cycle after acceptance. The block accepts one input word per
// cycle while the queue holds at most two words; the sustained rate is one
// input word per cycle as long as words cause at most one result each, and
// is otherwise set by the single output port draining one word per cycle.
// Reset clears the pending bit string and empties the queue. When the
// receiver stalls, the queue fills and o_in_ready drops until the queue
// has room for the two results a word may cause.
// ----------------------------------------------------------------------------
module char_to_prefix_code_transcoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ctp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ctp_pkg::t_out_word o_out_word
);
    import ctp_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [PEND_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_out_word         r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_qcount, n_qcount;
    t_dec_result       dec;
    logic              push_en;
    logic              pop_en;
    logic [1:0]        push_n;

    // Decode the incoming word against the pending state.
    ctp_decode u_decode (
        .i_word (i_in_word),
        .i_bits (r_bits),
        .i_cnt  (r_cnt),
        .o_res  (dec)
    );

    // Handshakes.
    assign o_in_ready  = (r_qcount <= QCNT_W'(QDEPTH - 2));
    assign push_en     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_qcount != '0);
    assign pop_en      = o_out_valid && i_out_ready;
    assign o_out_word  = r_queue[r_rd_ptr];
    assign push_n      = push_en ? dec.count : 2'd0;

    // Next pending state and queue pointers.
    always_comb begin
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        if (push_en && dec.upd) begin
            n_bits = dec.bits;
            n_cnt  = dec.cnt;
        end
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop_en);
        n_qcount = r_qcount + QCNT_W'(push_n) - QCNT_W'(pop_en);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits   <= '0;
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcount <= '0;
        end else begin
            r_bits   <= n_bits;
            r_cnt    <= n_cnt;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_qcount <= n_qcount;
        end
    end

    // Output queue storage.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= dec.word0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= dec.word1;
        end
    end

endmodule

/* rtl/core/ctp_checker.sv */
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks of the transcoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ctp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ctp_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ctp_pkg::t_out_word o_out_word
);
    import ctp_pkg::*;

    // A stalled output word stays valid.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload.
    a_out_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // An accepted end-of-line word always produces an output word.
    a_eol_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.kind == KIND_EOL |=> o_out_valid)
        else $error("end of line produced no output");

    // A line marker carries no character and closes its input word.
    a_line_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.line_end |->
            o_out_word.out_char == 8'd0 && o_out_word.last_of_item)
        else $error("malformed line marker");

endmodule

bind char_to_prefix_code_transcoder_unit ctp_checker u_ctp_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character to prefix-code transcoder. Letters,
// punctuation, unmapped bytes and end-of-line words are pushed through the
// block. A scoreboard keeps its own copy of the pending bit string,
// predicts the decoded characters and line markers of each accepted word,
// and compares every output word field by field in order. Both channels
// stall at random, the receiver once holds off long enough to back the
// block up, and the sender pauses until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;

    import ctp_pkg::*;

    localparam int NUM_RANDOM   = 1000;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_AFTER   = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    // Reference decoder and queue of expected output words.
    class transcode_scoreboard;
        t_out_word   decoded_q[$];
        logic [6:0]  pend_bits;
        logic [2:0]  pend_cnt;
        int unsigned n_errors;
        int unsigned n_checked;

        function new();
            pend_bits = '0;
            pend_cnt  = '0;
            n_errors  = 0;
            n_checked = 0;
        endfunction

        // Maps a character to its 5-bit code; returns 0 for unmapped bytes.
        function bit char_to_code(input logic [7:0] c, output logic [4:0] code);
            code = '0;
            if (c >= "A" && c <= "Z") begin
                code = 5'(c - "A");
                return 1'b1;
            end
            case (c)
                " ":     code = CODE_SPACE;
                ".":     code = CODE_PERIOD;
                ",":     code = CODE_COMMA;
                "-":     code = CODE_HYPHEN;
                "'":     code = CODE_APOSTR;
                "?":     code = CODE_QUESTION;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Prefix codeword lookup by length and right-aligned bits.
        function bit codeword_char(input logic [3:0] len, input logic [7:0] bits,
                                   output logic [7:0] ch);
            ch = '0;
            case ({len, bits})
                {4'd3, 8'h05}: ch = " ";
                {4'd6, 8'h00}: ch = "'";
                {4'd6, 8'h03}: ch = ",";
                {4'd8, 8'h91}: ch = "-";
                {4'd6, 8'h11}: ch = ".";
                {4'd6, 8'h01}: ch = "?";
                {4'd6, 8'h25}: ch = "A";
                {4'd8, 8'h9A}: ch = "B";
                {4'd4, 8'h05}: ch = "C";
                {4'd4, 8'h01}: ch = "D";
                {4'd3, 8'h06}: ch = "E";
                {4'd5, 8'h09}: ch = "F";
                {4'd8, 8'h9B}: ch = "G";
                {4'd6, 8'h10}: ch = "H";
                {4'd4, 8'h07}: ch = "I";
                {4'd8, 8'h98}: ch = "J";
                {4'd4, 8'h06}: ch = "K";
                {4'd5, 8'h04}: ch = "L";
                {4'd8, 8'h99}: ch = "M";
                {4'd8, 8'h9E}: ch = "N";
                {4'd5, 8'h05}: ch = "O";
                {4'd3, 8'h07}: ch = "P";
                {4'd8, 8'h9F}: ch = "Q";
                {4'd4, 8'h08}: ch = "R";
                {4'd5, 8'h06}: ch = "S";
                {4'd5, 8'h07}: ch = "T";
                {4'd8, 8'h9C}: ch = "U";
                {4'd8, 8'h9D}: ch = "V";
                {4'd6, 8'h02}: ch = "W";
                {4'd8, 8'h92}: ch = "X";
                {4'd8, 8'h93}: ch = "Y";
                {4'd8, 8'h90}: ch = "Z";
                default:       return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // Appends the code of an accepted word bit by bit and queues every
        // completed codeword, or a line marker for an end-of-line word.
        function void note_word(input t_in_word w);
            t_out_word  res;
            logic [4:0] code;
            logic [7:0] acc;
            logic [3:0] cnt;
            logic [7:0] ch;
            int         n;
            int         b;
            if (w.kind == KIND_EOL) begin
                pend_bits = '0;
                pend_cnt  = '0;
                res.out_char     = '0;
                res.line_end     = 1'b1;
                res.last_of_item = 1'b1;
                decoded_q.push_back(res);
                return;
            end
            if (!char_to_code(w.char_in, code)) return;
            acc = {1'b0, pend_bits};
            cnt = {1'b0, pend_cnt};
            n   = 0;
            for (b = 4; b >= 0; b--) begin
                acc = {acc[6:0], code[b]};
                cnt = cnt + 4'd1;
                if (codeword_char(cnt, acc, ch)) begin
                    if (n < 2) begin
                        res.out_char     = ch;
                        res.line_end     = 1'b0;
                        res.last_of_item = 1'b0;
                        decoded_q.push_back(res);
                        n++;
                    end
                    acc = '0;
                    cnt = '0;
                end else if (cnt >= 4'd8) begin
                    // Unreachable for a complete code; the string is dropped.
                    acc = '0;
                    cnt = '0;
                end
            end
            if (n > 0) begin
                res = decoded_q.pop_back();
                res.last_of_item = 1'b1;
                decoded_q.push_back(res);
            end
            pend_bits = acc[6:0];
            pend_cnt  = cnt[2:0];
        endfunction

        // Compares an output word with the oldest expected one.
        function void check_word(input t_out_word got);
            t_out_word exp_w;
            if (decoded_q.size() == 0) begin
                $error("unexpected output word: out_char %h line_end %b last_of_item %b",
                       got.out_char, got.line_end, got.last_of_item);
                n_errors++;
                return;
            end
            exp_w = decoded_q.pop_front();
            n_checked++;
            if (got.out_char !== exp_w.out_char) begin
                $error("out_char mismatch: expected %h, actual %h",
                       exp_w.out_char, got.out_char);
                n_errors++;
            end
            if (got.line_end !== exp_w.line_end) begin
                $error("line_end mismatch: expected %b, actual %b",
                       exp_w.line_end, got.line_end);
                n_errors++;
            end
            if (got.last_of_item !== exp_w.last_of_item) begin
                $error("last_of_item mismatch: expected %b, actual %b",
                       exp_w.last_of_item, got.last_of_item);
                n_errors++;
            end
        endfunction

        function int unsigned waiting();
            return decoded_q.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_word   in_word   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;

    bit          tail_phase     = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned stall_cycles   = 0;

    transcode_scoreboard sb = new();

    char_to_prefix_code_transcoder_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Record accepted words on both channels.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_word(in_word);
            if (out_valid && out_ready) sb.check_word(out_word);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Receiver: random stalls plus one long hold that backs the block up.
    initial begin
        while (!rst_n) @(posedge clk);
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (!long_hold_done && sb.n_checked >= HOLD_AFTER) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
                long_hold_done = 1'b1;
            end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one word and holds it until it is accepted.
    task automatic send_word(input t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_char(input logic [7:0] c);
        t_in_word w;
        w.kind    = KIND_CHAR;
        w.char_in = c;
        send_word(w);
    endtask

    task automatic send_eol(input logic [7:0] c);
        t_in_word w;
        w.kind    = KIND_EOL;
        w.char_in = c;
        send_word(w);
    endtask

    task automatic sender_idle(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops offering words until every expected output word has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] code_to_char(input logic [4:0] code);
        logic [7:0] c;
        c = "A" + 8'(code);
        case (code)
            CODE_SPACE:    c = " ";
            CODE_PERIOD:   c = ".";
            CODE_COMMA:    c = ",";
            CODE_HYPHEN:   c = "-";
            CODE_APOSTR:   c = "'";
            CODE_QUESTION: c = "?";
            default:       ;
        endcase
        return c;
    endfunction

    // Mostly mapped characters, then raw bytes and line ends.
    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            w.kind    = KIND_CHAR;
            w.char_in = code_to_char(5'($urandom_range(0, 31)));
        end else if (pick < 88) begin
            w.kind    = KIND_CHAR;
            w.char_in = 8'($urandom_range(0, 255));
        end else begin
            w.kind    = KIND_EOL;
            w.char_in = 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    // Main stimulus.
    initial begin
        int unsigned k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: table ends, punctuation, unmapped bytes, line ends.
        send_char("A");
        send_char("Z");
        send_char(" ");
        send_char("?");
        send_char("'");
        send_char(".");
        send_char(",");
        send_char("-");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h40);
        send_char(8'h5B);
        send_char(8'h61);
        send_eol(8'h00);
        send_eol(8'hFF);
        send_char("P");
        send_char("Q");
        send_char("B");
        send_char("E");
        send_eol(8'h41);
        send_char("T");
        send_char(" ");
        send_char("M");
        wait_drained();

        // Random words with idle bursts; the tail runs at full rate.
        for (k = 0; k < NUM_RANDOM; k++) begin
            tail_phase = (k >= NUM_RANDOM - TAIL_ITEMS);
            if (k == NUM_RANDOM / 2) wait_drained();
            if (!tail_phase && $urandom_range(0, 7) == 0) begin
                sender_idle($urandom_range(1, 13));
            end
            send_word(random_word());
        end

        wait_drained();
        if (sb.n_errors == 0 && sb.waiting() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ctp_pkg.sv
rtl/core/ctp_decode.sv
rtl/core/char_to_prefix_code_transcoder_unit.sv
rtl/core/ctp_checker.sv
tb/tb_top.sv
